// ===== hdl/multichannel_moving_average_core_defines.svh =====
// Assertion macros used by the checker file
`ifndef MULTICHANNEL_MOVING_AVERAGE_CORE_DEFINES_SVH
`define MULTICHANNEL_MOVING_AVERAGE_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define MMA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define MMA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/mma_pkg.sv =====
package mma_pkg;

   // Fixed field widths
   localparam int CFG_W    = 60;
   localparam int FIELD_W  = 5;
   localparam int CHAN_W   = 4;
   localparam int SPEED_W  = 16;
   localparam int SAMPLE_W = 8;
   localparam int SUM_W    = 13;
   localparam int MAG_W    = 12;
   localparam int CNT_W    = $clog2(MAG_W + 1);
   localparam int Q_DEPTH  = 2;

   // Saturation limits of a speed sample
   localparam logic signed [SPEED_W-1:0] SPEED_MAX = 16'sd127;
   localparam logic signed [SPEED_W-1:0] SPEED_MIN = -16'sd128;

   // Request commands
   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // Job kinds passed from front to back
   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_ZERO   = 2'd1;
   localparam logic [1:0] KIND_FILTER = 2'd2;

   typedef struct packed {
      logic [1:0]                 kind;
      logic [CHAN_W-1:0]          chan_idx;
      logic [FIELD_W-1:0]         win;
      logic signed [SAMPLE_W-1:0] sample;
   } job_type;

endpackage

// ===== hdl/mma_front.sv =====
module mma_front import mma_pkg::*; #(
   parameter int CHANNELS   = 12,
   parameter int MAX_WINDOW = 20
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_cmd,
   input  logic [CHAN_W-1:0]         req_channel,
   input  logic signed [SPEED_W-1:0] req_speed,
   output logic                      req_stall,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CFG_W-1:0]          csr_wdata,
   input  logic                      q_full,
   output logic                      q_push,
   output job_type                   q_job
);

   logic [CFG_W-1:0]           win_cfg_ff;
   logic [CFG_W-1:0]           win_cfg_in;
   logic                       chan_ok;
   logic [CHAN_W-1:0]          chan_idx;
   logic [CHAN_W-1:0]          idx_sel;
   logic [FIELD_W-1:0]         field;
   logic [FIELD_W-1:0]         win;
   logic signed [SAMPLE_W-1:0] sample;

   // Window length register, always writable
   assign csr_ready  = 1'b1;
   assign win_cfg_in = (csr_valid && csr_ready) ? csr_wdata : win_cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_cfg_ff <= '0;
      end else begin
         win_cfg_ff <= win_cfg_in;
      end
   end

   // Channel lookup and window clamp
   assign chan_ok  = (req_channel != '0) && (req_channel <= CHAN_W'(CHANNELS));
   assign chan_idx = req_channel - 1'b1;
   assign idx_sel  = chan_ok ? chan_idx : '0;
   assign field    = win_cfg_ff[idx_sel*FIELD_W +: FIELD_W];
   assign win      = (field > FIELD_W'(MAX_WINDOW)) ? FIELD_W'(MAX_WINDOW) : field;

   // Speed saturation
   always_comb begin
      if (req_speed > SPEED_MAX) begin
         sample = SPEED_MAX[SAMPLE_W-1:0];
      end else if (req_speed < SPEED_MIN) begin
         sample = SPEED_MIN[SAMPLE_W-1:0];
      end else begin
         sample = req_speed[SAMPLE_W-1:0];
      end
   end

   // Classify the request into a job
   always_comb begin
      q_job.chan_idx = idx_sel;
      q_job.win      = win;
      q_job.sample   = sample;
      if (req_cmd == CMD_CLEAR) begin
         q_job.kind = KIND_CLEAR;
      end else if (!chan_ok || win == '0) begin
         q_job.kind = KIND_ZERO;
      end else begin
         q_job.kind = KIND_FILTER;
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

// ===== hdl/mma_job_fifo.sv =====
module mma_job_fifo import mma_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type job_in,
   output logic    full,
   input  logic    pop,
   output logic    vld,
   output job_type job_out
);

   localparam int PTR_W = $clog2(Q_DEPTH);

   job_type                entry_ff [Q_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff;
   logic [PTR_W-1:0]       wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff;
   logic [PTR_W-1:0]       rd_ptr_in;
   logic [PTR_W:0]         count_ff;
   logic [PTR_W:0]         count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full    = (count_ff == (PTR_W + 1)'(Q_DEPTH));
   assign vld     = (count_ff != '0);
   assign job_out = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && vld;

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

// ===== hdl/mma_back.sv =====
module mma_back import mma_pkg::*; #(
   parameter int CHANNELS   = 12,
   parameter int MAX_WINDOW = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       q_vld,
   input  job_type                    q_job,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_filtered_speed
);

   localparam int DEPTH  = CHANNELS * MAX_WINDOW;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_WALK = 3'd1;
   localparam logic [2:0] ST_HEAD = 3'd2;
   localparam logic [2:0] ST_PREP = 3'd3;
   localparam logic [2:0] ST_DIV  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   // History memory and per-entry valid bits
   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [DEPTH-1:0]    vld_ff;

   logic [2:0]                 state_ff, state_in;
   logic [ADDR_W-1:0]          base_ff, base_in;
   logic [FIELD_W-1:0]         rd_k_ff, rd_k_in;
   logic [FIELD_W-1:0]         wr_k_ff, wr_k_in;
   logic                       pend_ff, pend_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [FIELD_W-1:0]         win_ff, win_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic                       neg_ff, neg_in;
   logic [MAG_W-1:0]           dvd_ff, dvd_in;
   logic [FIELD_W-1:0]         rem_ff, rem_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic                       rd_vld_ff;

   logic                       rd_en;
   logic [ADDR_W-1:0]          rd_addr;
   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic signed [SAMPLE_W-1:0] wr_data;
   logic                       vld_clr;
   logic                       rsp_load;
   logic signed [SAMPLE_W-1:0] hist_val;
   logic [FIELD_W:0]           trial;
   logic [FIELD_W:0]           diff;
   logic                       ge;
   logic [MAG_W-1:0]           mag;
   logic [SAMPLE_W-1:0]        quo;

   // Entries never written since reset or clear read as zero
   assign hist_val = rd_vld_ff ? rd_data_ff : '0;

   // Restoring divide step
   assign trial = {rem_ff, dvd_ff[MAG_W-1]};
   assign diff  = trial - {1'b0, win_ff};
   assign ge    = (trial >= {1'b0, win_ff});
   assign mag   = sum_ff[SUM_W-1] ? MAG_W'(-sum_ff) : MAG_W'(sum_ff);
   assign quo   = dvd_ff[SAMPLE_W-1:0];

   assign rsp_load = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      base_in   = base_ff;
      rd_k_in   = rd_k_ff;
      wr_k_in   = wr_k_ff;
      pend_in   = pend_ff;
      sample_in = sample_ff;
      win_in    = win_ff;
      sum_in    = sum_ff;
      neg_in    = neg_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      q_pop     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = base_ff + ADDR_W'(rd_k_ff - 1'b1);
      wr_en     = 1'b0;
      wr_addr   = base_ff;
      wr_data   = sample_ff;
      vld_clr   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_vld) begin
               q_pop = 1'b1;
               unique case (q_job.kind)
                  KIND_CLEAR: begin
                     vld_clr = 1'b1;
                  end
                  KIND_FILTER: begin
                     base_in   = ADDR_W'(q_job.chan_idx * MAX_WINDOW);
                     rd_k_in   = q_job.win - 1'b1;
                     pend_in   = 1'b0;
                     sum_in    = '0;
                     sample_in = q_job.sample;
                     win_in    = q_job.win;
                     state_in  = ST_WALK;
                  end
                  default: begin
                     dvd_in   = '0;
                     neg_in   = 1'b0;
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_WALK: begin
            // read slot k-1 while writing the value read in the previous cycle into the slot above it
            if (rd_k_ff != '0) begin
               rd_en   = 1'b1;
               wr_k_in = rd_k_ff;
               rd_k_in = rd_k_ff - 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = base_ff + ADDR_W'(wr_k_ff);
               wr_data = hist_val;
               sum_in  = sum_ff + SUM_W'(hist_val);
            end
            if (rd_k_ff == '0 && !pend_ff) begin
               state_in = ST_HEAD;
            end
         end
         ST_HEAD: begin
            wr_en    = 1'b1;
            sum_in   = sum_ff + SUM_W'(sample_ff);
            state_in = ST_PREP;
         end
         ST_PREP: begin
            neg_in   = sum_ff[SUM_W-1];
            dvd_in   = mag;
            rem_in   = '0;
            cnt_in   = CNT_W'(MAG_W);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (cnt_ff != '0) begin
               dvd_in = {dvd_ff[MAG_W-2:0], ge};
               rem_in = ge ? diff[FIELD_W-1:0] : trial[FIELD_W-1:0];
               cnt_in = cnt_ff - 1'b1;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output register
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in = neg_ff ? SAMPLE_W'(~quo + 1'b1) : quo;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_speed = rsp_data_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      rd_k_ff     <= rd_k_in;
      wr_k_ff     <= wr_k_in;
      sample_ff   <= sample_in;
      win_ff      <= win_in;
      sum_ff      <= sum_in;
      neg_ff      <= neg_in;
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Valid bits: cleared by reset and by the clear request
   always_ff @(posedge clock) begin
      if (reset || vld_clr) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[wr_addr] <= 1'b1;
      end
   end

   // History memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_vld_ff  <= vld_ff[rd_addr];
      end
   end

endmodule

// ===== hdl/multichannel_moving_average_core.sv =====
// Sequence: a filter request walks the window history, writes the head sample, sets up
// the divide, runs the 12-step restoring divider and loads the result register.
// Zero-result requests go straight to loading the result register; clear gives none.
// The back end serves one request at a time, and a stalled result holds it. Reset (sync,
// active high) zeroes window lengths and invalidates all history.
module multichannel_moving_average_core import mma_pkg::*; #(
   parameter int CHANNELS   = 12,
   parameter int MAX_WINDOW = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_cmd,
   input  logic [CHAN_W-1:0]          req_channel,
   input  logic signed [SPEED_W-1:0]  req_speed,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_filtered_speed,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CFG_W-1:0]           csr_wdata
);

   logic    q_full;
   logic    q_push;
   logic    q_pop;
   logic    q_vld;
   job_type q_job_in;
   job_type q_job_out;

   // Front: config register and request classification
   mma_front #(
      .CHANNELS   (CHANNELS),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_cmd     (req_cmd),
      .req_channel (req_channel),
      .req_speed   (req_speed),
      .req_stall   (req_stall),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_wdata   (csr_wdata),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (q_job_in)
   );

   // Job queue between front and back
   mma_job_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .job_in  (q_job_in),
      .full    (q_full),
      .pop     (q_pop),
      .vld     (q_vld),
      .job_out (q_job_out)
   );

   // Back: history walk, divide and result register
   mma_back #(
      .CHANNELS   (CHANNELS),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_vld              (q_vld),
      .q_job              (q_job_out),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_speed (rsp_filtered_speed)
   );

endmodule

// ===== hdl/mma_checker.sv =====
`include "multichannel_moving_average_core_defines.svh"

module mma_checker import mma_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_stall,
   input logic                       rsp_valid,
   input logic                       rsp_stall,
   input logic signed [SAMPLE_W-1:0] rsp_filtered_speed,
   input logic                       csr_ready
);

   // No result is pending right after reset
   `MMA_ASSERT_NOW(a_no_rsp_after_reset, clock, reset, $past(reset), !rsp_valid, "result valid after reset")

   // Queue is empty right after reset, so requests are taken
   `MMA_ASSERT_NOW(a_no_stall_after_reset, clock, reset, $past(reset), !req_stall, "stall after reset")

   // Config port never back-pressures
   `MMA_ASSERT_NOW(a_csr_ready, clock, reset, 1'b1, csr_ready, "csr_ready dropped")

   // Stalled result holds
   `MMA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_filtered_speed), "stalled result changed")

endmodule

bind multichannel_moving_average_core mma_checker u_checker (.*);
